// ===== rtl/core/cubic_bezier_tessellator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// cubic bezier tessellator assertion macros
// shared concurrent check forms, clocked on the rising edge, off in reset
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_TESSELLATOR_UNIT_MACROS_SVH
`define CUBIC_BEZIER_TESSELLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define CBT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbt: same-cycle check failed");

// next-cycle implication
`define CBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbt: next-cycle check failed");

`endif

// ===== rtl/core/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbt_pkg
// types and fixed widths shared by the cubic bezier tessellator
// ----------------------------------------------------------------------------
`default_nettype none

package cbt_pkg;

    // coordinate and count widths
    localparam int COORD_W      = 16;
    localparam int SEG_W        = 6;
    localparam int MAX_SEGMENTS = 63;

    // t in Q0.16 plus one integer bit so that t = 1.0 is representable
    localparam int T_W     = 17;
    localparam int SQ_W    = 2 * T_W;
    localparam int W_W     = 49;
    localparam int FRAC_W  = 48;
    localparam int PROD_W  = W_W + 1 + COORD_W;

    // 2^16 / n takes one quotient bit per step
    localparam int DIV_STEPS = T_W;

    // curves waiting between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [T_W-1:0] T_ONE = {1'b1, {(T_W-1){1'b0}}};

    // one curve
    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] ctrl_a_x;
        logic signed [COORD_W-1:0] ctrl_a_y;
        logic signed [COORD_W-1:0] ctrl_b_x;
        logic signed [COORD_W-1:0] ctrl_b_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic        [SEG_W-1:0]   segment_count;
    } cbt_in_t;

    // one curve point
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic        [SEG_W-1:0]   point_index;
        logic                      last_point;
    } cbt_out_t;

    // classified curve: control points by order, clamped count, t step
    typedef struct packed {
        logic [3:0][COORD_W-1:0] cx;
        logic [3:0][COORD_W-1:0] cy;
        logic [SEG_W-1:0]        seg;
        logic [T_W-1:0]          step_q;
        logic [SEG_W-1:0]        step_r;
    } cbt_job_t;

endpackage

`default_nettype wire

// ===== rtl/core/cbt_front.sv =====
// ----------------------------------------------------------------------------
// cbt_front
// accepts curves, clamps the count and works out the exact t step 2^16 / n
// ----------------------------------------------------------------------------
`default_nettype none
`include "cubic_bezier_tessellator_unit_macros.svh"

module cbt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              curve_valid,
    output logic              curve_stall,
    input  cbt_pkg::cbt_in_t  curve_data,
    output logic              push,
    output cbt_pkg::cbt_job_t push_data,
    input  logic              q_full
);
    import cbt_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        FS_IDLE = 3'b001,
        FS_DIV  = 3'b010,
        FS_PUSH = 3'b100
    } fstate_t;

    fstate_t          state_reg, state_next;
    cbt_job_t         job_reg, job_next;
    logic [T_W-1:0]   quo_reg, quo_next;
    logic [SEG_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic [SEG_W-1:0] seg_clamped;
    logic [SEG_W:0]   rem_shift;
    logic [SEG_W:0]   rem_diff;
    logic             fits;

    assign curve_stall = (state_reg != FS_IDLE);
    assign accept      = curve_valid && !curve_stall;

    // count above the supported maximum is clamped
    always_comb
    begin
        if (curve_data.segment_count > SEG_W'(MAX_SEGMENTS))
        begin
            seg_clamped = SEG_W'(MAX_SEGMENTS);
        end
        else
        begin
            seg_clamped = curve_data.segment_count;
        end
    end

    // restoring divide step: dividend is 2^16, its only set bit enters first
    always_comb
    begin
        rem_shift = {rem_reg, (cnt_reg == CNT_W'(DIV_STEPS - 1))};
        fits      = (rem_shift >= {1'b0, job_reg.seg});
        rem_diff  = rem_shift - {1'b0, job_reg.seg};
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (accept)
                begin
                    job_next.cx     = {curve_data.end_x, curve_data.ctrl_b_x,
                                       curve_data.ctrl_a_x, curve_data.start_x};
                    job_next.cy     = {curve_data.end_y, curve_data.ctrl_b_y,
                                       curve_data.ctrl_a_y, curve_data.start_y};
                    job_next.seg    = seg_clamped;
                    job_next.step_q = '0;
                    job_next.step_r = '0;
                    quo_next        = '0;
                    rem_next        = '0;
                    cnt_next        = CNT_W'(DIV_STEPS - 1);
                    // zero segments needs no step
                    state_next      = (seg_clamped == '0) ? FS_PUSH : FS_DIV;
                end
            end
            FS_DIV:
            begin
                quo_next = {quo_reg[T_W-2:0], fits};
                rem_next = fits ? rem_diff[SEG_W-1:0] : rem_shift[SEG_W-1:0];
                if (cnt_reg == '0)
                begin
                    state_next = FS_PUSH;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            FS_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    // hand the classified curve to the queue
    always_comb
    begin
        push_data        = job_reg;
        push_data.step_q = quo_reg;
        push_data.step_r = rem_reg;
    end

    assign push = (state_reg == FS_PUSH) && !q_full;

    // state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // curve and divider data
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    // divider keeps a proper remainder and ends with an exact split of 2^16
    `CBT_ASSERT_IMPL(a_div_rem_below_seg, clk, rst_n, state_reg == FS_DIV, rem_reg < job_reg.seg)
    `CBT_ASSERT_IMPL(a_step_exact, clk, rst_n, state_reg == FS_PUSH && job_reg.seg != '0, (32'(quo_reg) * 32'(job_reg.seg) + 32'(rem_reg)) == 32'h10000)

endmodule

`default_nettype wire

// ===== rtl/core/cbt_queue.sv =====
// ----------------------------------------------------------------------------
// cbt_queue
// short queue of classified curves between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module cbt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cbt_pkg::cbt_job_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output cbt_pkg::cbt_job_t head
);
    import cbt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cbt_job_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cbt_back.sv =====
// ----------------------------------------------------------------------------
// cbt_back
// steps t exactly over a curve and evaluates the bernstein cubic per point
// ----------------------------------------------------------------------------
`default_nettype none
`include "cubic_bezier_tessellator_unit_macros.svh"

module cbt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  cbt_pkg::cbt_job_t head,
    output logic              pop,
    output logic              point_valid,
    input  logic              point_stall,
    output cbt_pkg::cbt_out_t point_data
);
    import cbt_pkg::*;

    localparam int TX_W   = T_W + 2;
    localparam int W0_W   = SQ_W + T_W;
    localparam int W1_W   = SQ_W + TX_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int TOT_W  = PROD_W + 2;
    localparam int Q_W    = TOT_W - FRAC_W;
    localparam logic [T_W-1:0] T_MAX = T_ONE - T_W'(1);
    localparam logic [TOT_W-1:0] ROUND_HALF = TOT_W'(1) << (FRAC_W - 1);
    localparam logic signed [Q_W-1:0] Q_HI =
        {{(Q_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_LO =
        {{(Q_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [Q_W-1:0] q);
        logic signed [COORD_W-1:0] r;
        if (q > Q_HI)
        begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (q < Q_LO)
        begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            r = q[COORD_W-1:0];
        end
        return r;
    endfunction

    // point sequencer
    logic [SEG_W-1:0] idx_reg, idx_next;
    logic [T_W-1:0]   t_acc_reg, t_acc_next;
    logic [SEG_W-1:0] rem_reg, rem_next;
    logic             adv;
    logic             issue;
    logic             is_first;
    logic             is_last;
    logic [SEG_W-1:0] rem_cur;
    logic [T_W-1:0]   t_cur;
    logic [SEG_W:0]   rem_sum;
    logic             wrap;
    logic [SEG_W:0]   rem_wrapped;
    logic [T_W-1:0]   t_step;
    logic [T_W-1:0]   t_issue;

    // pipeline stages
    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                    s4_valid_reg, s5_valid_reg, out_valid_reg;
    logic [T_W-1:0]          s1_t_reg, s1_u_reg;
    logic [3:0][COORD_W-1:0] s1_cx_reg, s1_cy_reg;
    logic [SEG_W-1:0]        s1_idx_reg;
    logic                    s1_last_reg;

    logic [SQ_W-1:0]         s2_uu_reg, s2_uu_next, s2_tt_reg, s2_tt_next;
    logic [T_W-1:0]          s2_u_reg, s2_t_reg;
    logic [TX_W-1:0]         s2_u3_reg, s2_u3_next, s2_t3_reg, s2_t3_next;
    logic [3:0][COORD_W-1:0] s2_cx_reg, s2_cy_reg;
    logic [SEG_W-1:0]        s2_idx_reg;
    logic                    s2_last_reg;

    logic [W0_W-1:0]         w0_full, w3_full;
    logic [W1_W-1:0]         w1_full, w2_full;
    logic [3:0][W_W-1:0]     s3_w_reg, s3_w_next;
    logic [3:0][COORD_W-1:0] s3_cx_reg, s3_cy_reg;
    logic [SEG_W-1:0]        s3_idx_reg;
    logic                    s3_last_reg;

    logic signed [PROD_W-1:0] s4_px_reg [4];
    logic signed [PROD_W-1:0] s4_py_reg [4];
    logic signed [PROD_W-1:0] s4_px_next [4];
    logic signed [PROD_W-1:0] s4_py_next [4];
    logic [SEG_W-1:0]         s4_idx_reg;
    logic                     s4_last_reg;

    logic signed [SUM_W-1:0] s5_x01_reg, s5_x23_reg, s5_y01_reg, s5_y23_reg;
    logic signed [SUM_W-1:0] s5_x01_next, s5_x23_next, s5_y01_next, s5_y23_next;
    logic [SEG_W-1:0]        s5_idx_reg;
    logic                    s5_last_reg;

    logic [TOT_W-1:0]        tot_x, tot_y;
    cbt_out_t                point_data_reg, point_data_next;

    // whole pipeline moves unless a finished point is held by the consumer
    assign adv   = !out_valid_reg || !point_stall;
    assign issue = adv && q_valid;

    // exact t = floor((i * 2^16 + n/2) / n) by quotient and remainder steps
    always_comb
    begin
        is_first    = (idx_reg == '0);
        is_last     = (idx_reg == head.seg);
        rem_cur     = is_first ? (head.seg >> 1) : rem_reg;
        t_cur       = is_first ? '0 : t_acc_reg;
        rem_sum     = {1'b0, rem_cur} + {1'b0, head.step_r};
        wrap        = (rem_sum >= {1'b0, head.seg});
        rem_wrapped = wrap ? (rem_sum - {1'b0, head.seg}) : rem_sum;
        t_step      = t_cur + head.step_q + T_W'(wrap);
        // final point runs with t = 1.0, which gives the end point exactly
        if (is_last)
        begin
            t_issue = T_ONE;
        end
        else if (t_cur[T_W-1])
        begin
            t_issue = T_MAX;
        end
        else
        begin
            t_issue = t_cur;
        end
    end

    assign pop = issue && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        t_acc_next = t_acc_reg;
        rem_next   = rem_reg;
        if (issue)
        begin
            if (is_last)
            begin
                idx_next = '0;
            end
            else
            begin
                idx_next   = idx_reg + SEG_W'(1);
                t_acc_next = t_step;
                rem_next   = rem_wrapped[SEG_W-1:0];
            end
        end
    end

    // squares and tripled t, u
    always_comb
    begin
        s2_uu_next = s1_u_reg * s1_u_reg;
        s2_tt_next = s1_t_reg * s1_t_reg;
        s2_u3_next = TX_W'(s1_u_reg) + (TX_W'(s1_u_reg) << 1);
        s2_t3_next = TX_W'(s1_t_reg) + (TX_W'(s1_t_reg) << 1);
    end

    // bernstein weights, their sum is exactly 2^48
    always_comb
    begin
        w0_full      = s2_uu_reg * s2_u_reg;
        w1_full      = s2_uu_reg * s2_t3_reg;
        w2_full      = s2_tt_reg * s2_u3_reg;
        w3_full      = s2_tt_reg * s2_t_reg;
        s3_w_next[0] = w0_full[W_W-1:0];
        s3_w_next[1] = w1_full[W_W-1:0];
        s3_w_next[2] = w2_full[W_W-1:0];
        s3_w_next[3] = w3_full[W_W-1:0];
    end

    // weight times coordinate, one lane per control point
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            s4_px_next[k] = $signed({1'b0, s3_w_reg[k]}) * $signed(s3_cx_reg[k]);
            s4_py_next[k] = $signed({1'b0, s3_w_reg[k]}) * $signed(s3_cy_reg[k]);
        end
    end

    // pairwise sums
    always_comb
    begin
        s5_x01_next = SUM_W'(s4_px_reg[0]) + SUM_W'(s4_px_reg[1]);
        s5_x23_next = SUM_W'(s4_px_reg[2]) + SUM_W'(s4_px_reg[3]);
        s5_y01_next = SUM_W'(s4_py_reg[0]) + SUM_W'(s4_py_reg[1]);
        s5_y23_next = SUM_W'(s4_py_reg[2]) + SUM_W'(s4_py_reg[3]);
    end

    // final sum, round half up at 2^-48, saturate
    always_comb
    begin
        tot_x = TOT_W'(s5_x01_reg) + TOT_W'(s5_x23_reg) + ROUND_HALF;
        tot_y = TOT_W'(s5_y01_reg) + TOT_W'(s5_y23_reg) + ROUND_HALF;
        point_data_next.point_x     = sat_coord($signed(tot_x[TOT_W-1:FRAC_W]));
        point_data_next.point_y     = sat_coord($signed(tot_y[TOT_W-1:FRAC_W]));
        point_data_next.point_index = s5_idx_reg;
        point_data_next.last_point  = s5_last_reg;
    end

    assign point_valid = out_valid_reg;
    assign point_data  = point_data_reg;

    // sequencer and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (adv)
            begin
                s1_valid_reg  <= issue;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                s5_valid_reg  <= s4_valid_reg;
                out_valid_reg <= s5_valid_reg;
            end
        end
    end

    // stepping state and stage data
    always_ff @(posedge clk)
    begin
        t_acc_reg <= t_acc_next;
        rem_reg   <= rem_next;
        if (adv)
        begin
            s1_t_reg       <= t_issue;
            s1_u_reg       <= T_ONE - t_issue;
            s1_cx_reg      <= head.cx;
            s1_cy_reg      <= head.cy;
            s1_idx_reg     <= idx_reg;
            s1_last_reg    <= is_last;

            s2_uu_reg      <= s2_uu_next;
            s2_tt_reg      <= s2_tt_next;
            s2_u_reg       <= s1_u_reg;
            s2_t_reg       <= s1_t_reg;
            s2_u3_reg      <= s2_u3_next;
            s2_t3_reg      <= s2_t3_next;
            s2_cx_reg      <= s1_cx_reg;
            s2_cy_reg      <= s1_cy_reg;
            s2_idx_reg     <= s1_idx_reg;
            s2_last_reg    <= s1_last_reg;

            s3_w_reg       <= s3_w_next;
            s3_cx_reg      <= s2_cx_reg;
            s3_cy_reg      <= s2_cy_reg;
            s3_idx_reg     <= s2_idx_reg;
            s3_last_reg    <= s2_last_reg;

            s4_px_reg      <= s4_px_next;
            s4_py_reg      <= s4_py_next;
            s4_idx_reg     <= s3_idx_reg;
            s4_last_reg    <= s3_last_reg;

            s5_x01_reg     <= s5_x01_next;
            s5_x23_reg     <= s5_x23_next;
            s5_y01_reg     <= s5_y01_next;
            s5_y23_reg     <= s5_y23_next;
            s5_idx_reg     <= s4_idx_reg;
            s5_last_reg    <= s4_last_reg;

            point_data_reg <= point_data_next;
        end
    end

    // mid-curve stepping keeps a proper remainder and t below one
    `CBT_ASSERT_IMPL(a_rem_below_seg, clk, rst_n, q_valid && idx_reg != '0, rem_reg < head.seg)
    `CBT_ASSERT_IMPL(a_t_below_one, clk, rst_n, q_valid && idx_reg != '0 && idx_reg != head.seg, !t_acc_reg[T_W-1])
    // finishing a curve restarts the sequencer at its first point
    `CBT_ASSERT_NEXT(a_restart_after_pop, clk, rst_n, pop, idx_reg == '0)

endmodule

`default_nettype wire

// ===== rtl/core/cubic_bezier_tessellator_unit.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_tessellator_unit
// tessellates cubic bezier curves into n+1 points in signed Q12.4
// ----------------------------------------------------------------------------
//  channel  | signals                               | carries
//  ---------+---------------------------------------+---------------------------
//  curve    | curve_valid, curve_stall, curve_data  | one curve: 4 points, count
//  point    | point_valid, point_stall, point_data  | one point, index, last flag
//
//  points leave one per cycle while a curve is queued and point_stall is low,
//  behind a 17-step divider for 2^16 / n in the front; each point runs
//  through stages s1 to s5 and then the output register.
//  reset clears control only; no clearing pass.
//  point_stall freezes the evaluation pipeline; the two-entry queue lets the
//  front keep accepting curves meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_tessellator_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              curve_valid,
    output logic              curve_stall,
    input  cbt_pkg::cbt_in_t  curve_data,
    output logic              point_valid,
    input  logic              point_stall,
    output cbt_pkg::cbt_out_t point_data
);
    import cbt_pkg::*;

    logic     push;
    cbt_job_t push_data;
    logic     q_full;
    logic     q_valid;
    logic     pop;
    cbt_job_t head;

    // accept and classify
    cbt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .curve_valid (curve_valid),
        .curve_stall (curve_stall),
        .curve_data  (curve_data),
        .push        (push),
        .push_data   (push_data),
        .q_full      (q_full)
    );

    // decoupling queue
    cbt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .head      (head)
    );

    // point evaluation
    cbt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .head        (head),
        .pop         (pop),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point_data  (point_data)
    );

endmodule

`default_nettype wire
